// File: rtl/dfr_pkg.sv
package dfr_pkg;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = 2;

  // Header magic in wire order: index 0 is the first byte on the wire.
  localparam logic [3:0][7:0] HDR_SIGNATURE = {8'h33, 8'h50, 8'h45, 8'h53};

  localparam logic REG_NAME_LENGTH = 1'b0;
  localparam logic REG_DIR_LENGTH  = 1'b1;

  typedef logic [3:0] magic_class_t;

  typedef struct packed {
    logic [7:0]   data;
    logic         last;
    magic_class_t cls;
  } dfr_item_t;

  // Bit i is set when the byte equals magic byte i.
  function automatic magic_class_t classify(input logic [7:0] b);
    magic_class_t c;
    for (int i = 0; i < 4; i++) begin
      c[i] = (b == HDR_SIGNATURE[i]);
    end
    return c;
  endfunction

endpackage

// File: rtl/dfr_regs.sv
module dfr_regs (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [15:0] name_length,
  output logic [15:0] dir_length
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      name_length <= '0;
      dir_length  <= '0;
    end else if (wr_en) begin
      unique case (paddr[2])
        dfr_pkg::REG_NAME_LENGTH: name_length <= pwdata[15:0];
        dfr_pkg::REG_DIR_LENGTH:  dir_length  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      dfr_pkg::REG_NAME_LENGTH: prdata = {16'b0, name_length};
      dfr_pkg::REG_DIR_LENGTH:  prdata = {16'b0, dir_length};
      default:                  prdata = '0;
    endcase
  end

endmodule

// File: rtl/dfr_front.sv
module dfr_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        byte_value,
  input  logic              final_byte,
  output logic              item_valid,
  output dfr_pkg::dfr_item_t item,
  input  logic              item_pop
);

  dfr_pkg::dfr_item_t                  items [dfr_pkg::QUEUE_DEPTH];
  logic [dfr_pkg::QUEUE_AW-1:0]        wr_ptr;
  logic [dfr_pkg::QUEUE_AW-1:0]        rd_ptr;
  logic [dfr_pkg::QUEUE_AW:0]          count;
  logic                                push;

  assign in_stall   = (count == (dfr_pkg::QUEUE_AW + 1)'(dfr_pkg::QUEUE_DEPTH));
  assign push       = in_valid && !in_stall;
  assign item_valid = (count != '0);
  assign item       = items[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      items[wr_ptr].data <= byte_value;
      items[wr_ptr].last <= final_byte;
      items[wr_ptr].cls  <= dfr_pkg::classify(byte_value);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (item_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, item_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: rtl/dfr_back.sv
module dfr_back #(
  parameter int IMAGE_WIDTH  = 128,
  parameter int IMAGE_HEIGHT = 128,
  parameter int HEADER_BYTES = 15
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  input  dfr_pkg::dfr_item_t item,
  output logic               item_pop,
  input  logic [15:0]        name_length,
  input  logic [15:0]        dir_length,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [6:0]         pixel_row,
  output logic [6:0]         pixel_col,
  output logic [7:0]         red_level,
  output logic [7:0]         green_level,
  output logic [7:0]         blue_level
);

  localparam int CW = $clog2(IMAGE_WIDTH > 1 ? IMAGE_WIDTH : 2);
  localparam int RW = $clog2(IMAGE_HEIGHT + 1);
  localparam logic [CW-1:0] COL_LAST  = CW'(IMAGE_WIDTH - 1);
  localparam logic [RW-1:0] ROW_FULL  = RW'(IMAGE_HEIGHT);
  localparam logic [17:0]   SKIP_BASE = 18'(HEADER_BYTES - 4);

  logic [7:0]             win [3];
  dfr_pkg::magic_class_t  win_cls [3];
  logic [1:0]             fill;
  logic [17:0]            skip;
  logic [CW-1:0]          col;
  logic [RW-1:0]          row;
  logic                   halted;

  logic [7:0]             win_next [3];
  dfr_pkg::magic_class_t  win_cls_next [3];
  logic [1:0]             fill_next;
  logic [17:0]            skip_next;
  logic [CW-1:0]          col_next;
  logic [RW-1:0]          row_next;
  logic                   halted_next;

  logic                   full;
  logic                   magic;
  logic                   emit;
  logic                   advance;

  assign item_pop = item_valid && (!out_valid || !out_stall);
  assign full     = (row == ROW_FULL);
  assign magic    = win_cls[0][0] && win_cls[1][1] && win_cls[2][2] && item.cls[3];

  always_comb begin
    win_next     = win;
    win_cls_next = win_cls;
    fill_next    = fill;
    skip_next    = skip;
    halted_next  = halted;
    emit         = 1'b0;
    if (item_pop && !halted) begin
      if (skip != '0) begin
        skip_next = skip - 1'b1;
      end else if (fill == 2'd3) begin
        if (magic) begin
          fill_next = 2'd0;
          skip_next = SKIP_BASE + 18'(name_length) + 18'(dir_length);
        end else if (!full) begin
          // The fourth byte stays as the first byte of the next position.
          emit            = 1'b1;
          fill_next       = 2'd1;
          win_next[0]     = item.data;
          win_cls_next[0] = item.cls;
        end else begin
          halted_next = 1'b1;
        end
      end else begin
        case (fill)
          2'd0: begin
            win_next[0]     = item.data;
            win_cls_next[0] = item.cls;
          end
          2'd1: begin
            win_next[1]     = item.data;
            win_cls_next[1] = item.cls;
          end
          default: begin
            win_next[2]     = item.data;
            win_cls_next[2] = item.cls;
          end
        endcase
        fill_next = fill + 1'b1;
        // A three-byte tail still makes a pixel.
        if (item.last && fill == 2'd2 && !full) begin
          emit = 1'b1;
        end
      end
    end
    if (item_pop && item.last) begin
      fill_next   = 2'd0;
      skip_next   = '0;
      halted_next = 1'b0;
    end
  end

  assign advance = emit;

  always_comb begin
    col_next = col;
    row_next = row;
    if (advance) begin
      if (col == COL_LAST) begin
        col_next = '0;
        row_next = row + 1'b1;
      end else begin
        col_next = col + 1'b1;
      end
    end
    if (item_pop && item.last) begin
      col_next = '0;
      row_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    win     <= win_next;
    win_cls <= win_cls_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill   <= '0;
      skip   <= '0;
      col    <= '0;
      row    <= '0;
      halted <= 1'b0;
    end else begin
      fill   <= fill_next;
      skip   <= skip_next;
      col    <= col_next;
      row    <= row_next;
      halted <= halted_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      out_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      pixel_row   <= 7'(row);
      pixel_col   <= 7'(col);
      red_level   <= win[0];
      green_level <= win[1];
      blue_level  <= (fill == 2'd3) ? win[2] : item.data;
    end
  end

endmodule

// File: rtl/image_stream_deframer_unit.sv
// Channel   Direction  Handshake            Payload
// input     in         in_valid / in_stall  byte_value, final_byte
// output    out        out_valid/out_stall  pixel_row, pixel_col, red/green/blue_level
// config    in         APB psel/penable     paddr, pwdata, prdata (name_length, dir_length)
//
// One byte is taken per cycle unless in_stall is high. A pixel is registered when the
// byte after its blue byte or a final blue byte is popped; at most one per three bytes.
// A four-entry byte queue separates input acceptance from the stateful back end,
// so input keeps flowing for up to four bytes while the output is stalled.
// Synchronous reset empties the queue and clears all framing state and config registers.
module image_stream_deframer_unit #(
  parameter int IMAGE_WIDTH  = 128,
  parameter int IMAGE_HEIGHT = 128,
  parameter int HEADER_BYTES = 15
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  byte_value,
  input  logic        final_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [6:0]  pixel_row,
  output logic [6:0]  pixel_col,
  output logic [7:0]  red_level,
  output logic [7:0]  green_level,
  output logic [7:0]  blue_level,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic               item_valid;
  logic               item_pop;
  dfr_pkg::dfr_item_t item;
  logic [15:0]        name_length;
  logic [15:0]        dir_length;

  dfr_regs u_regs (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .name_length (name_length),
    .dir_length  (dir_length)
  );

  dfr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .byte_value (byte_value),
    .final_byte (final_byte),
    .item_valid (item_valid),
    .item       (item),
    .item_pop   (item_pop)
  );

  dfr_back #(
    .IMAGE_WIDTH  (IMAGE_WIDTH),
    .IMAGE_HEIGHT (IMAGE_HEIGHT),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item        (item),
    .item_pop    (item_pop),
    .name_length (name_length),
    .dir_length  (dir_length),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .pixel_row   (pixel_row),
    .pixel_col   (pixel_col),
    .red_level   (red_level),
    .green_level (green_level),
    .blue_level  (blue_level)
  );

endmodule

// File: rtl/dfr_checker.sv
module dfr_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [6:0]  pixel_row,
  input logic [6:0]  pixel_col,
  input logic [7:0]  red_level,
  input logic [7:0]  green_level,
  input logic [7:0]  blue_level,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [2:0]  paddr,
  input logic [31:0] pwdata,
  input logic [31:0] prdata
);

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("outputs not idle after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(pixel_row) && $stable(pixel_col) &&
      $stable(red_level) && $stable(green_level) && $stable(blue_level))
    else $error("stalled pixel request changed");

  a_readback: assert property (@(posedge clk) disable iff (rst)
    (psel && penable && pwrite) ##1 (psel && !pwrite && paddr[2] == $past(paddr[2]))
      |-> prdata[15:0] == $past(pwdata[15:0]))
    else $error("register readback mismatch");

  a_prdata_upper: assert property (@(posedge clk) disable iff (rst)
    psel |-> prdata[31:16] == 16'b0)
    else $error("unused register bits not zero");

endmodule

bind image_stream_deframer_unit dfr_checker u_dfr_checker (
  .clk         (clk),
  .rst         (rst),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .pixel_row   (pixel_row),
  .pixel_col   (pixel_col),
  .red_level   (red_level),
  .green_level (green_level),
  .blue_level  (blue_level),
  .psel        (psel),
  .penable     (penable),
  .pwrite      (pwrite),
  .paddr       (paddr),
  .pwdata      (pwdata),
  .prdata      (prdata)
);
